// ===== design/fcms_pkg.sv =====
// fcms_pkg: shared types and constants for the forest cell markov step core
// stand codes and configuration register indexes; no dependencies
package fcms_pkg;

  localparam int unsigned NumRates = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned NumStand = 4;

  typedef enum logic [1:0] {
    StandDec = 2'd0,
    StandCon = 2'd1,
    StandTrn = 2'd2,
    StandMix = 2'd3
  } stand_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMixFromDec = 4'd0,
    RegMixFromCon = 4'd1,
    RegMixToCon   = 4'd2,
    RegMixToDec   = 4'd3,
    RegRegenDec   = 4'd4,
    RegRegenCon   = 4'd5,
    RegRegenMix   = 4'd6,
    RegDisturb    = 4'd7
  } cfg_reg_e;

endpackage

// ===== design/fcms_cfg.sv =====
// fcms_cfg: the eight rate registers behind the configuration write port
// depends on fcms_pkg for register indexes
module fcms_cfg import fcms_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]                     cfg_index_i,
  input  logic [FRAC_BITS-1:0]                   cfg_data_i,
  output logic [NumRates-1:0][FRAC_BITS-1:0]     rates_o
);

  localparam logic [63:0] One = 64'd1 << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] RstHalf    = FRAC_BITS'(One >> 1);
  localparam logic [FRAC_BITS-1:0] RstQuarter = FRAC_BITS'(One >> 2);
  localparam logic [FRAC_BITS-1:0] RstFifth   = FRAC_BITS'((One * 64'd2 + 64'd5) / 64'd10);
  localparam logic [FRAC_BITS-1:0] RstTenth   = FRAC_BITS'((One + 64'd5) / 64'd10);

  logic [NumRates-1:0][FRAC_BITS-1:0] rates_q, rates_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    rates_d = rates_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegMixFromDec: rates_d[RegMixFromDec] = cfg_data_i;
        RegMixFromCon: rates_d[RegMixFromCon] = cfg_data_i;
        RegMixToCon:   rates_d[RegMixToCon]   = cfg_data_i;
        RegMixToDec:   rates_d[RegMixToDec]   = cfg_data_i;
        RegRegenDec:   rates_d[RegRegenDec]   = cfg_data_i;
        RegRegenCon:   rates_d[RegRegenCon]   = cfg_data_i;
        RegRegenMix:   rates_d[RegRegenMix]   = cfg_data_i;
        RegDisturb:    rates_d[RegDisturb]    = cfg_data_i;
        default:       rates_d = rates_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rates_q[RegMixFromDec] <= RstHalf;
      rates_q[RegMixFromCon] <= RstHalf;
      rates_q[RegMixToCon]   <= RstQuarter;
      rates_q[RegMixToDec]   <= RstQuarter;
      rates_q[RegRegenDec]   <= RstFifth;
      rates_q[RegRegenCon]   <= RstFifth;
      rates_q[RegRegenMix]   <= RstFifth;
      rates_q[RegDisturb]    <= RstTenth;
    end else begin
      rates_q <= rates_d;
    end
  end

  assign rates_o = rates_q;

endmodule

// ===== design/fcms_prob.sv =====
// fcms_prob: forms the four transition probabilities from the current stand
// depends on fcms_pkg for stand codes and register indexes
module fcms_prob import fcms_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  stand_e                                 stand_i,
  input  logic [NumRates-1:0][FRAC_BITS-1:0]     rates_i,
  input  logic [FRAC_BITS-1:0]                   share_deciduous_i,
  input  logic [FRAC_BITS-1:0]                   share_coniferous_i,
  input  logic [FRAC_BITS-1:0]                   share_mixed_i,
  output logic [NumStand-1:0][FRAC_BITS:0]       prob_o
);

  localparam int unsigned PW = FRAC_BITS + 1;
  localparam int unsigned UW = FRAC_BITS + 2;
  localparam int unsigned MW = 2 * FRAC_BITS + 1;
  localparam logic [PW-1:0] One = PW'(1) << FRAC_BITS;

  logic [FRAC_BITS-1:0] col_rate;
  logic [PW-1:0]        col_sum;
  logic [MW-1:0]        col_prod;
  logic [PW-1:0]        col_scaled;
  logic [PW-1:0]        col_prob;
  logic [UW-1:0]        used;
  logic [PW-1:0]        rest;

  // one shared multiplier: only the two pure stands colonize
  always_comb begin
    if (stand_i == StandCon) begin
      col_rate = rates_i[RegMixFromCon];
      col_sum  = {1'b0, share_mixed_i} + {1'b0, share_deciduous_i};
    end else begin
      col_rate = rates_i[RegMixFromDec];
      col_sum  = {1'b0, share_coniferous_i} + {1'b0, share_mixed_i};
    end
    col_prod   = MW'(col_rate) * MW'(col_sum);
    col_scaled = col_prod[MW-1:FRAC_BITS];
    col_prob   = (col_scaled > One) ? One : col_scaled;
  end

  always_comb begin
    unique case (stand_i)
      StandDec, StandCon: used = UW'({1'b0, rates_i[RegDisturb]}) + UW'(col_prob);
      StandTrn: used = UW'(rates_i[RegRegenDec]) + UW'(rates_i[RegRegenCon])
                       + UW'(rates_i[RegRegenMix]);
      default:  used = UW'(rates_i[RegMixToDec]) + UW'(rates_i[RegMixToCon])
                       + UW'(rates_i[RegDisturb]);
    endcase
    // complement floored at zero
    rest = (used >= UW'(One)) ? '0 : PW'(UW'(One) - used);
  end

  always_comb begin
    unique case (stand_i)
      StandDec: begin
        prob_o[StandDec] = rest;
        prob_o[StandCon] = '0;
        prob_o[StandTrn] = PW'(rates_i[RegDisturb]);
        prob_o[StandMix] = col_prob;
      end
      StandCon: begin
        prob_o[StandDec] = '0;
        prob_o[StandCon] = rest;
        prob_o[StandTrn] = PW'(rates_i[RegDisturb]);
        prob_o[StandMix] = col_prob;
      end
      StandTrn: begin
        prob_o[StandDec] = PW'(rates_i[RegRegenDec]);
        prob_o[StandCon] = PW'(rates_i[RegRegenCon]);
        prob_o[StandTrn] = rest;
        prob_o[StandMix] = PW'(rates_i[RegRegenMix]);
      end
      default: begin
        prob_o[StandDec] = PW'(rates_i[RegMixToDec]);
        prob_o[StandCon] = PW'(rates_i[RegMixToCon]);
        prob_o[StandTrn] = PW'(rates_i[RegDisturb]);
        prob_o[StandMix] = rest;
      end
    endcase
  end

endmodule

// ===== design/fcms_select.sv =====
// fcms_select: walks the cumulative probabilities against the random value
// depends on fcms_pkg for stand codes
module fcms_select import fcms_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic [FRAC_BITS-1:0]                   random_fraction_i,
  input  logic [NumStand-1:0][FRAC_BITS:0]       prob_i,
  output stand_e                                 next_o
);

  localparam int unsigned AW = FRAC_BITS + 3;

  logic [AW-1:0] acc_dec, acc_con, acc_trn, acc_mix;
  logic [AW-1:0] rnd;

  always_comb begin
    rnd     = AW'(random_fraction_i);
    acc_dec = AW'(prob_i[StandDec]);
    acc_con = acc_dec + AW'(prob_i[StandCon]);
    acc_trn = acc_con + AW'(prob_i[StandTrn]);
    acc_mix = acc_trn + AW'(prob_i[StandMix]);
    // no running sum above the random value falls back to mixed
    priority if (rnd < acc_dec) begin
      next_o = StandDec;
    end else if (rnd < acc_con) begin
      next_o = StandCon;
    end else if (rnd < acc_trn) begin
      next_o = StandTrn;
    end else if (rnd < acc_mix) begin
      next_o = StandMix;
    end else begin
      next_o = StandMix;
    end
  end

endmodule

// ===== design/forest_cell_markov_step_core.sv =====
// forest_cell_markov_step_core: top level of one cell's forest stand markov chain
// depends on fcms_pkg, fcms_cfg, fcms_prob and fcms_select
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in      | to core   | in_valid_i / in_stall_o | random_fraction, share_* (FRAC_BITS)
//   out     | from core | out_valid_o/out_stall_i | next_stand (2 bits)
//   cfg     | to core   | cfg_valid_i/cfg_ready_o | cfg_index_i (4 bits), cfg_data_i
//
// one request per cycle sustained while the result drains; a request passes an input
// register, then probability and selection logic (one multiplier) into the result register.
// the stored stand updates as an item moves into the result register, so the next item sees it.
// reset: stand is deciduous, rates take their defaults, both registers empty.
// in_stall_o rises only while the input register holds a request and the result cannot drain.
module forest_cell_markov_step_core import fcms_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FRAC_BITS-1:0] random_fraction_i,
  input  logic [FRAC_BITS-1:0] share_deciduous_i,
  input  logic [FRAC_BITS-1:0] share_coniferous_i,
  input  logic [FRAC_BITS-1:0] share_mixed_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           next_stand_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [FRAC_BITS-1:0] cfg_data_i
);

  localparam int unsigned AW = FRAC_BITS + 3;

  logic [NumRates-1:0][FRAC_BITS-1:0] rates;
  logic [NumStand-1:0][FRAC_BITS:0]   prob;
  stand_e                             next_stand;

  logic                 s1_valid_q, s1_valid_d;
  logic [FRAC_BITS-1:0] s1_rand_q, s1_sd_q, s1_sc_q, s1_sm_q;
  stand_e               stand_q, stand_d;
  logic                 out_valid_q, out_valid_d;
  stand_e               out_stand_q;
  logic                 advance;
  logic                 in_take;
  logic [AW-1:0]        prob_total;

  fcms_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rates_o     (rates)
  );

  fcms_prob #(.FRAC_BITS(FRAC_BITS)) u_prob (
    .stand_i            (stand_q),
    .rates_i            (rates),
    .share_deciduous_i  (s1_sd_q),
    .share_coniferous_i (s1_sc_q),
    .share_mixed_i      (s1_sm_q),
    .prob_o             (prob)
  );

  fcms_select #(.FRAC_BITS(FRAC_BITS)) u_select (
    .random_fraction_i (s1_rand_q),
    .prob_i            (prob),
    .next_o            (next_stand)
  );

  // result register frees up when empty or being taken this cycle
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = in_take || (s1_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && out_stall_i);
    stand_d     = advance ? next_stand : stand_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      stand_q     <= StandDec;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      stand_q     <= stand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_rand_q <= random_fraction_i;
      s1_sd_q   <= share_deciduous_i;
      s1_sc_q   <= share_coniferous_i;
      s1_sm_q   <= share_mixed_i;
    end
    if (advance) begin
      out_stand_q <= next_stand;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_stand_o = out_stand_q;

  assign prob_total = AW'(prob[StandDec]) + AW'(prob[StandCon])
                    + AW'(prob[StandTrn]) + AW'(prob[StandMix]);

  // the held result always matches the stored stand
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_stand_q == stand_q))
    else $error("result differs from stored stand");

  // stand only changes when a request moves into the result register
  a_state_moves_with_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(stand_q))
    else $error("stand changed without a request");

  // probabilities always cover the whole unit interval, so a real state is picked
  a_prob_covers_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (prob_total >= (AW'(1) << FRAC_BITS)))
    else $error("transition probabilities sum below one");

  // a request waiting in the input register is never dropped
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_rand_q)))
    else $error("pending request lost");

endmodule

// ===== dv/tb_forest_cell_markov_step_core.sv =====
// tb_forest_cell_markov_step_core: self-checking testbench for the forest stand markov step core
// needs fcms_pkg and forest_cell_markov_step_core; stimulus and expected stands are built in place
`timescale 1ns / 1ps

module tb_forest_cell_markov_step_core;
  import fcms_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned LongHold = 64;
  localparam int unsigned ProdW    = 2 * FracBits + 3;

  typedef logic [FracBits-1:0] frac_t;
  typedef logic [FracBits+2:0] prob_t;

  localparam prob_t One     = prob_t'(1) << FracBits;
  localparam frac_t FracMax = '1;
  localparam frac_t FracHalf = frac_t'(One >> 1);

  typedef struct packed {
    frac_t rnd;
    frac_t share_dec;
    frac_t share_con;
    frac_t share_mix;
  } forest_req_t;

  logic               clk_i              = 1'b0;
  logic               rst_ni             = 1'b0;
  logic               in_valid_i         = 1'b0;
  logic               in_stall_o;
  frac_t              random_fraction_i  = '0;
  frac_t              share_deciduous_i  = '0;
  frac_t              share_coniferous_i = '0;
  frac_t              share_mixed_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i        = 1'b0;
  logic [1:0]         next_stand_o;
  logic               cfg_valid_i        = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i        = '0;
  frac_t              cfg_data_i         = '0;

  // testbench copy of the rate registers and the stored stand
  frac_t       rate_q [NumRates];
  stand_e      model_stand = StandDec;
  stand_e      stand_due_q[$];
  forest_req_t req_q[$];
  forest_req_t cur_req;

  int unsigned mismatch_cnt  = 0;
  int unsigned send_gap      = 0;
  int unsigned recv_wait     = 0;
  int unsigned hold_left     = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  bit          burst_mode    = 1'b0;

  forest_cell_markov_step_core #(
    .FRAC_BITS(FracBits)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .random_fraction_i (random_fraction_i),
    .share_deciduous_i (share_deciduous_i),
    .share_coniferous_i(share_coniferous_i),
    .share_mixed_i     (share_mixed_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .next_stand_o      (next_stand_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // floor(rate * share_sum / one), saturated at one
  function automatic prob_t mix_chance(frac_t rate, prob_t share_sum);
    logic [ProdW-1:0] prod;
    prod = ProdW'(rate) * ProdW'(share_sum);
    prod = prod >> FracBits;
    return (prod > One) ? One : prob_t'(prod);
  endfunction

  function automatic prob_t left_over(prob_t used);
    return (used >= One) ? prob_t'(0) : One - used;
  endfunction

  function automatic stand_e stand_after_step(stand_e cur, frac_t rnd, frac_t sd, frac_t sc,
                                              frac_t sm);
    prob_t  p [NumStand];
    prob_t  run;
    stand_e nxt;
    run = '0;
    nxt = StandMix;
    case (cur)
      StandDec: begin
        p[StandCon] = '0;
        p[StandTrn] = prob_t'(rate_q[RegDisturb]);
        p[StandMix] = mix_chance(rate_q[RegMixFromDec], prob_t'(sc) + prob_t'(sm));
        p[StandDec] = left_over(p[StandTrn] + p[StandMix]);
      end
      StandCon: begin
        p[StandDec] = '0;
        p[StandTrn] = prob_t'(rate_q[RegDisturb]);
        p[StandMix] = mix_chance(rate_q[RegMixFromCon], prob_t'(sm) + prob_t'(sd));
        p[StandCon] = left_over(p[StandTrn] + p[StandMix]);
      end
      StandTrn: begin
        p[StandDec] = prob_t'(rate_q[RegRegenDec]);
        p[StandCon] = prob_t'(rate_q[RegRegenCon]);
        p[StandMix] = prob_t'(rate_q[RegRegenMix]);
        p[StandTrn] = left_over(p[StandDec] + p[StandCon] + p[StandMix]);
      end
      default: begin
        p[StandDec] = prob_t'(rate_q[RegMixToDec]);
        p[StandCon] = prob_t'(rate_q[RegMixToCon]);
        p[StandTrn] = prob_t'(rate_q[RegDisturb]);
        p[StandMix] = left_over(p[StandDec] + p[StandCon] + p[StandTrn]);
      end
    endcase
    // first running sum above the random value wins, mixed if none does
    for (int k = 0; k < NumStand; k++) begin
      run = run + p[k[1:0]];
      if (rnd < run) begin
        nxt = stand_e'(k[1:0]);
        break;
      end
    end
    return nxt;
  endfunction

  // driver: offers requests from req_q, books the expected stand on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i         <= 1'b0;
      random_fraction_i  <= '0;
      share_deciduous_i  <= '0;
      share_coniferous_i <= '0;
      share_mixed_i      <= '0;
      send_gap = 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        model_stand = stand_after_step(model_stand, random_fraction_i, share_deciduous_i,
                                       share_coniferous_i, share_mixed_i);
        stand_due_q.push_back(model_stand);
        send_gap = burst_mode ? 0 : $urandom_range(0, 3);
      end
      if (send_gap == 0 && req_q.size() != 0) begin
        cur_req = req_q.pop_front();
        in_valid_i         <= 1'b1;
        random_fraction_i  <= cur_req.rnd;
        share_deciduous_i  <= cur_req.share_dec;
        share_coniferous_i <= cur_req.share_con;
        share_mixed_i      <= cur_req.share_mix;
      end else begin
        if (send_gap != 0) send_gap--;
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: checks each accepted result and draws the receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (stand_due_q.size() == 0) begin
          mismatch_cnt++;
          $error("next_stand: expected none, actual %0d", next_stand_o);
        end else begin
          if (next_stand_o !== stand_due_q[0]) begin
            mismatch_cnt++;
            $error("next_stand: expected %0d, actual %0d", stand_due_q[0], next_stand_o);
          end
          void'(stand_due_q.pop_front());
        end
        recv_wait = burst_mode ? 0 : $urandom_range(0, 3);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LongHold;
        out_stall_i <= 1'b1;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic frac_t frac_draw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FracMax;
      2:       return FracHalf;
      default: return frac_t'($urandom);
    endcase
  endfunction

  function automatic forest_req_t req_make(frac_t rnd, frac_t sd, frac_t sc, frac_t sm);
    forest_req_t req;
    req.rnd       = rnd;
    req.share_dec = sd;
    req.share_con = sc;
    req.share_mix = sm;
    return req;
  endfunction

  task automatic rate_write(logic [CfgIdxW-1:0] idx, frac_t val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    // indexes past the last register are dropped by the block
    if (idx < NumRates) rate_q[idx[2:0]] = val;
  endtask

  task automatic rates_set_all(int unsigned mode);
    cfg_reg_e reg_sel;
    reg_sel = reg_sel.first();
    repeat (NumRates) begin
      case (mode)
        0:       rate_write(reg_sel, '0);
        1:       rate_write(reg_sel, FracMax);
        default: rate_write(reg_sel, frac_draw());
      endcase
      reg_sel = reg_sel.next();
    end
    rate_write(CfgIdxW'(NumRates) + CfgIdxW'($urandom_range(0, 7)), frac_t'($urandom));
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid_i || stand_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_reqs(int unsigned count);
    repeat (count) req_q.push_back(req_make(frac_draw(), frac_draw(), frac_draw(),
                                            frac_draw()));
  endtask

  initial begin
    rate_q[RegMixFromDec] = frac_t'(One >> 1);
    rate_q[RegMixFromCon] = frac_t'(One >> 1);
    rate_q[RegMixToCon]   = frac_t'(One >> 2);
    rate_q[RegMixToDec]   = frac_t'(One >> 2);
    rate_q[RegRegenDec]   = frac_t'((One * 2 + 5) / 10);
    rate_q[RegRegenCon]   = frac_t'((One * 2 + 5) / 10);
    rate_q[RegRegenMix]   = frac_t'((One * 2 + 5) / 10);
    rate_q[RegDisturb]    = frac_t'((One + 5) / 10);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset rates: walk deciduous -> transitional -> mixed -> deciduous and beyond
    req_q.push_back(req_make(FracMax, '0, '0, '0));
    req_q.push_back(req_make(FracMax, '0, '0, '0));
    req_q.push_back(req_make('0, '0, '0, '0));
    req_q.push_back(req_make(FracMax, FracMax, FracMax, FracMax));
    req_q.push_back(req_make(frac_t'(20000), '0, '0, '0));
    req_q.push_back(req_make('0, FracMax, FracMax, FracMax));
    req_q.push_back(req_make(FracHalf, FracHalf, FracHalf, FracHalf));
    req_q.push_back(req_make(frac_t'(13106), '0, FracMax, '0));
    req_q.push_back(req_make(frac_t'(13107), FracMax, '0, FracMax));
    wait_drained();

    // saturated rates: running sums go past one
    rates_set_all(1);
    req_q.push_back(req_make('0, FracMax, FracMax, FracMax));
    req_q.push_back(req_make(FracMax, FracMax, FracMax, FracMax));
    req_q.push_back(req_make(FracHalf, '0, FracMax, FracMax));
    req_q.push_back(req_make(FracMax, '0, '0, '0));
    random_reqs(100);
    wait_drained();

    // all rates zero
    rates_set_all(0);
    req_q.push_back(req_make(FracMax, FracMax, FracMax, FracMax));
    req_q.push_back(req_make('0, '0, '0, '0));
    random_reqs(50);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      rates_set_all(2);
      random_reqs(150);
      if (phase == 2 || phase == 6) hold_requests++;
      burst_mode = (phase == 4);
      wait_drained();
      burst_mode = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && stand_due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
